// ----- rtl/nrl3fp_pkg.sv -----
`timescale 1ns / 1ps
package nrl3fp_pkg;

    localparam int HEADER_BYTES  = 20;
    localparam int REQUEST_BYTES = 35;

    localparam int POS_W  = 11;
    localparam int CALL_W = 56;
    localparam int HDR_W  = 48;
    localparam int PL_W   = 10;

    localparam logic [POS_W-1:0] POS_MAX      = 11'd2047;
    localparam logic [POS_W-1:0] POS_SRC_END  = 11'd7;
    localparam logic [POS_W-1:0] POS_DST_END  = 11'd14;
    localparam logic [POS_W-1:0] POS_HDR_END  = 11'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_WINDOW   = 11'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_USR_END  = 11'd28;
    localparam logic [POS_W-1:0] POS_NODE_END = 11'(REQUEST_BYTES);
    // Position of the last byte in a frame of exactly header or request length.
    localparam logic [POS_W-1:0] POS_HDR_LAST = 11'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_REQ_LAST = 11'(REQUEST_BYTES - 1);
    localparam logic [POS_W-1:0] PAYLOAD_MAX  = 11'd1023;

    localparam logic [7:0] CALL_MIN  = 8'h60;
    localparam logic [7:0] KIND_MASK = 8'h0F;

    localparam logic [3:0] KIND_CREQ = 4'd1;
    localparam logic [3:0] KIND_CACK = 4'd2;
    localparam logic [3:0] KIND_INFO = 4'd5;
    localparam logic [3:0] KIND_LAST = 4'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_NOT_CONN  = 3'd2;
    localparam logic [2:0] ST_BAD_OP    = 3'd3;
    localparam logic [2:0] ST_REQ_SHORT = 3'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int RES_BITS = 3 + 4 * CALL_W + 8 + 16 + 8 + 8 + 4 + 8 + PL_W;
    localparam int RES_PAD  = (8 - RES_BITS % 8) % 8;
    localparam int RES_W    = RES_BITS + RES_PAD;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CALL_W-1:0] src;
        logic [CALL_W-1:0] dst;
        logic [HDR_W-1:0]  hdr;
        logic [7:0]        win;
        logic [CALL_W-1:0] usr;
        logic [CALL_W-1:0] node;
    } frame_rec_t;

    // Members listed from the top bit down, so status sits in the lowest bits.
    typedef struct packed {
        logic [RES_PAD-1:0] pad;
        logic [PL_W-1:0]    payload_length;
        logic [CALL_W-1:0]  node_call;
        logic [CALL_W-1:0]  user_call;
        logic [7:0]         window_size;
        logic [3:0]         frame_kind;
        logic [7:0]         receive_sequence;
        logic [7:0]         send_sequence;
        logic [15:0]        circuit;
        logic [7:0]         time_to_live;
        logic [CALL_W-1:0]  dest_call;
        logic [CALL_W-1:0]  source_call;
        logic [2:0]         status;
    } result_t;

    typedef struct packed {
        logic       push;
        frame_rec_t rec;
    } queue_wr_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        frame_rec_t head;
    } queue_rd_t;

endpackage

// ----- rtl/nrl3fp_front.sv -----
`timescale 1ns / 1ps
module nrl3fp_front
    import nrl3fp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       beat,
    input  logic [7:0] frame_byte,
    input  logic       last_byte,
    output queue_wr_t  qwr
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CALL_W-1:0] src_reg, src_next, src_upd;
    logic [CALL_W-1:0] dst_reg, dst_next, dst_upd;
    logic [HDR_W-1:0]  hdr_reg, hdr_next, hdr_upd;
    logic [7:0]        win_reg, win_next, win_upd;
    logic [CALL_W-1:0] usr_reg, usr_next, usr_upd;
    logic [CALL_W-1:0] node_reg, node_next, node_upd;

    always_comb begin
        src_upd  = src_reg;
        dst_upd  = dst_reg;
        hdr_upd  = hdr_reg;
        win_upd  = win_reg;
        usr_upd  = usr_reg;
        node_upd = node_reg;
        if (pos_reg < POS_SRC_END) begin
            src_upd = {src_reg[CALL_W-9:0], frame_byte};
        end else if (pos_reg < POS_DST_END) begin
            dst_upd = {dst_reg[CALL_W-9:0], frame_byte};
        end else if (pos_reg < POS_HDR_END) begin
            hdr_upd = {hdr_reg[HDR_W-9:0], frame_byte};
        end else if (pos_reg == POS_WINDOW) begin
            win_upd = frame_byte;
        end else if (pos_reg < POS_USR_END) begin
            usr_upd = {usr_reg[CALL_W-9:0], frame_byte};
        end else if (pos_reg < POS_NODE_END) begin
            node_upd = {node_reg[CALL_W-9:0], frame_byte};
        end

        pos_next  = pos_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        hdr_next  = hdr_reg;
        win_next  = win_reg;
        usr_next  = usr_reg;
        node_next = node_reg;
        if (beat) begin
            if (last_byte) begin
                pos_next  = '0;
                src_next  = '0;
                dst_next  = '0;
                hdr_next  = '0;
                win_next  = '0;
                usr_next  = '0;
                node_next = '0;
            end else begin
                pos_next  = (pos_reg < POS_MAX) ? pos_reg + 11'd1 : pos_reg;
                src_next  = src_upd;
                dst_next  = dst_upd;
                hdr_next  = hdr_upd;
                win_next  = win_upd;
                usr_next  = usr_upd;
                node_next = node_upd;
            end
        end

        qwr.push     = beat && last_byte;
        qwr.rec.pos  = pos_reg;
        qwr.rec.src  = src_upd;
        qwr.rec.dst  = dst_upd;
        qwr.rec.hdr  = hdr_upd;
        qwr.rec.win  = win_upd;
        qwr.rec.usr  = usr_upd;
        qwr.rec.node = node_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            src_reg  <= '0;
            dst_reg  <= '0;
            hdr_reg  <= '0;
            win_reg  <= '0;
            usr_reg  <= '0;
            node_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            src_reg  <= src_next;
            dst_reg  <= dst_next;
            hdr_reg  <= hdr_next;
            win_reg  <= win_next;
            usr_reg  <= usr_next;
            node_reg <= node_next;
        end
    end

endmodule

// ----- rtl/nrl3fp_queue.sv -----
`timescale 1ns / 1ps
module nrl3fp_queue
    import nrl3fp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  queue_wr_t qwr,
    input  logic      pop,
    output queue_rd_t qrd
);

    frame_rec_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    always_comb begin
        qrd.empty = (count_reg == '0);
        qrd.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
        qrd.head  = mem_reg[rd_ptr_reg];
        do_push   = qwr.push && !qrd.full;
        do_pop    = pop && !qrd.empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= qwr.rec;
        end
    end

endmodule

// ----- rtl/nrl3fp_back.sv -----
`timescale 1ns / 1ps
module nrl3fp_back
    import nrl3fp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  queue_rd_t qrd,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_data
);

    logic       valid_reg, valid_next;
    result_t    res_reg, res_next;
    frame_rec_t rec;
    logic [3:0] kind;
    logic [7:0] first_byte;
    logic [POS_W-1:0] payload;

    always_comb begin
        rec        = qrd.head;
        kind       = rec.hdr[3:0] & KIND_MASK[3:0];
        first_byte = rec.src[CALL_W-1 -: 8];
        payload    = rec.pos - POS_HDR_LAST;
        pop        = !qrd.empty && (!valid_reg || out_ready);

        res_next = '0;
        if (rec.pos < POS_HDR_LAST) begin
            res_next.status = ST_TOO_SHORT;
        end else if (first_byte < CALL_MIN) begin
            res_next.status = ST_NOT_CONN;
        end else if (!(kind inside {[KIND_CREQ:KIND_LAST]})) begin
            res_next.status = ST_BAD_OP;
        end else if (kind == KIND_CREQ && rec.pos < POS_REQ_LAST) begin
            res_next.status = ST_REQ_SHORT;
        end else begin
            res_next.status           = ST_OK;
            res_next.source_call      = rec.src;
            res_next.dest_call        = rec.dst;
            res_next.time_to_live     = rec.hdr[47:40];
            res_next.circuit          = rec.hdr[39:24];
            res_next.send_sequence    = rec.hdr[23:16];
            res_next.receive_sequence = rec.hdr[15:8];
            res_next.frame_kind       = kind;
            if (kind == KIND_CREQ) begin
                res_next.window_size = rec.win;
                res_next.user_call   = rec.usr;
                res_next.node_call   = rec.node;
            end else if (kind == KIND_CACK && rec.pos > POS_HDR_LAST) begin
                res_next.window_size = rec.win;
            end else if (kind == KIND_INFO) begin
                res_next.payload_length = (payload > PAYLOAD_MAX) ?
                    PAYLOAD_MAX[PL_W-1:0] : payload[PL_W-1:0];
            end
        end

        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

endmodule

// ----- rtl/netrom_l3_frame_parser_top.sv -----
`timescale 1ns / 1ps
// Takes one frame byte per cycle; s_tready drops only while two finished frames wait behind
// a stalled result register, set by the two-entry queue between capture and classification.
// A frame ending in s_tlast is queued, then classified into the result register (m_tvalid).
// Throughput: one byte per cycle while s_tready stays high, one result per frame.
// Reset (aresetn low, synchronous) clears the byte position, the captured fields,
// the queue and the output valid; no result is pending afterward.
module netrom_l3_frame_parser_top
    import nrl3fp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // frame_byte
    input  logic             s_tlast,   // last_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    // status, source_call, dest_call, time_to_live, circuit, send_sequence,
    // receive_sequence, frame_kind, window_size, user_call, node_call,
    // payload_length, zero pad
    output logic [RES_W-1:0] m_tdata
);

    queue_wr_t qwr;
    queue_rd_t qrd;
    logic      pop;
    result_t   res;

    assign s_tready = !qrd.full;

    nrl3fp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat       (s_tvalid && s_tready),
        .frame_byte (s_tdata),
        .last_byte  (s_tlast),
        .qwr        (qwr)
    );

    nrl3fp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .qwr     (qwr),
        .pop     (pop),
        .qrd     (qrd)
    );

    nrl3fp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qrd       (qrd),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = res;

endmodule

// ----- rtl/nrl3fp_checker.sv -----
`timescale 1ns / 1ps
module nrl3fp_checker
    import nrl3fp_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             s_tlast,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [RES_W-1:0] m_tdata
);

    result_t res;
    assign res = m_tdata;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.status <= ST_REQ_SHORT)
        else $error("status code out of range");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status != ST_OK |-> m_tdata[RES_W-1:3] == '0)
        else $error("error result carries nonzero fields");

    a_origin_creq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.frame_kind != KIND_CREQ |->
            res.user_call == '0 && res.node_call == '0)
        else $error("origin fields set outside a connect request");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast && !m_tvalid &&
            !$past(s_tvalid && s_tready && s_tlast) |=> !m_tvalid)
        else $error("result appeared one cycle after the last byte");

endmodule

bind netrom_l3_frame_parser_top nrl3fp_checker u_nrl3fp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/netrom_l3_frame_parser_top_test.sv -----
`timescale 1ns / 1ps
module netrom_l3_frame_parser_top_test;
    import nrl3fp_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam int LONG_HOLD = 300;
    localparam int RANDOM_BEATS = 150;
    localparam int RANDOM_FRAMES = 14;

    typedef struct {
        logic [7:0] data;
        logic       fin;
        int         gap;
        bit         drain;
        bit         stall;
    } beat_t;

    logic             aclk;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = 8'h00;
    logic             s_tlast = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [RES_W-1:0] m_tdata;

    beat_t   frame_beats[$];
    result_t awaited_results[$];

    logic [POS_W-1:0]  frame_pos = '0;
    logic [CALL_W-1:0] src_acc = '0;
    logic [CALL_W-1:0] dst_acc = '0;
    logic [HDR_W-1:0]  hdr_acc = '0;
    logic [7:0]        win_acc = '0;
    logic [CALL_W-1:0] usr_acc = '0;
    logic [CALL_W-1:0] node_acc = '0;

    int cycle_count = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int rx_hold = 0;
    int rx_steady = 0;
    bit in_fire = 1'b0;
    bit wind_down = 1'b0;

    netrom_l3_frame_parser_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] seen,
                                 input logic [63:0] wanted);
        if (seen !== wanted) begin
            flag_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                    results_seen, name, seen, wanted));
        end
    endtask

    // Captures one frame byte and, on the final byte, classifies the frame.
    task automatic parse_frame_byte(input logic [7:0] octet, input logic fin);
        logic [POS_W-1:0] at;
        logic [POS_W:0]   flen;
        logic [POS_W:0]   payload;
        logic [3:0]       kind;
        result_t          want;
        at = frame_pos;
        if (at < POS_SRC_END) begin
            src_acc = {src_acc[CALL_W-9:0], octet};
        end else if (at < POS_DST_END) begin
            dst_acc = {dst_acc[CALL_W-9:0], octet};
        end else if (at < POS_HDR_END) begin
            hdr_acc = {hdr_acc[HDR_W-9:0], octet};
        end else if (at == POS_WINDOW) begin
            win_acc = octet;
        end else if (at < POS_USR_END) begin
            usr_acc = {usr_acc[CALL_W-9:0], octet};
        end else if (at < POS_NODE_END) begin
            node_acc = {node_acc[CALL_W-9:0], octet};
        end
        if (frame_pos != POS_MAX) begin
            frame_pos = frame_pos + 1'b1;
        end
        if (fin) begin
            flen = {1'b0, at} + 1'b1;
            kind = 4'(hdr_acc[7:0] & KIND_MASK);
            want = '0;
            if (flen < HEADER_BYTES) begin
                want.status = ST_TOO_SHORT;
            end else if (src_acc[CALL_W-1:CALL_W-8] < CALL_MIN) begin
                want.status = ST_NOT_CONN;
            end else if (kind < KIND_CREQ || kind > KIND_LAST) begin
                want.status = ST_BAD_OP;
            end else if (kind == KIND_CREQ && flen < REQUEST_BYTES) begin
                want.status = ST_REQ_SHORT;
            end else begin
                want.status = ST_OK;
                want.source_call = src_acc;
                want.dest_call = dst_acc;
                want.time_to_live = hdr_acc[47:40];
                want.circuit = hdr_acc[39:24];
                want.send_sequence = hdr_acc[23:16];
                want.receive_sequence = hdr_acc[15:8];
                want.frame_kind = kind;
                if (kind == KIND_CREQ) begin
                    want.window_size = win_acc;
                    want.user_call = usr_acc;
                    want.node_call = node_acc;
                end else if (kind == KIND_CACK && flen > HEADER_BYTES) begin
                    want.window_size = win_acc;
                end else if (kind == KIND_INFO) begin
                    payload = flen - 12'(HEADER_BYTES);
                    want.payload_length = (payload > PAYLOAD_MAX) ?
                        PAYLOAD_MAX[PL_W-1:0] : payload[PL_W-1:0];
                end
            end
            awaited_results.push_back(want);
            frame_pos = '0;
            src_acc = '0;
            dst_acc = '0;
            hdr_acc = '0;
            win_acc = '0;
            usr_acc = '0;
            node_acc = '0;
        end
    endtask

    task automatic queue_frame(input int flen, input logic [7:0] lead,
                               input logic [7:0] opcode, input bit paced,
                               input bit drain, input bit stall);
        beat_t b;
        int    r;
        for (int i = 0; i < flen; i++) begin
            b.data = (i == 0) ? lead : (i == 19) ? opcode : 8'($urandom);
            b.fin = (i == flen - 1);
            r = $urandom_range(0, 99);
            if (!paced || r < 70) begin
                b.gap = 0;
            end else if (r < 95) begin
                b.gap = $urandom_range(1, 3);
            end else begin
                b.gap = $urandom_range(8, 30);
            end
            b.drain = drain && (i == 0);
            b.stall = stall && (i == 0);
            frame_beats.push_back(b);
        end
    endtask

    always @(negedge aclk) begin : offer_bytes
        beat_t head;
        if (aresetn && (!s_tvalid || in_fire)) begin
            if (frame_beats.size() == 0 ||
                (frame_beats[0].drain && awaited_results.size() != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                head = frame_beats[0];
                if (head.gap > 0) begin
                    head.gap = head.gap - 1;
                    frame_beats[0] = head;
                    s_tvalid <= 1'b0;
                end else begin
                    void'(frame_beats.pop_front());
                    s_tvalid <= 1'b1;
                    s_tdata <= head.data;
                    s_tlast <= head.fin;
                    if (head.stall) begin
                        hold_asks <= hold_asks + 1;
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin : accept_results
        int r;
        r = $urandom_range(0, 999);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (wind_down) begin
            m_tready <= 1'b1;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            rx_hold <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_steady > 0) begin
            rx_steady <= rx_steady - 1;
            m_tready <= 1'b1;
        end else if (r < 5) begin
            rx_hold <= $urandom_range(10, 40);
            m_tready <= 1'b0;
        end else if (r < 15) begin
            rx_steady <= $urandom_range(50, 150);
            m_tready <= 1'b1;
        end else begin
            m_tready <= (r % 100) < 70;
        end
    end

    always @(posedge aclk) begin : observe
        result_t got;
        result_t want;
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            in_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                results_seen++;
                if (awaited_results.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with none pending",
                                            results_seen));
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", 64'(got.status), 64'(want.status));
                    compare_field("source_call", 64'(got.source_call),
                                  64'(want.source_call));
                    compare_field("dest_call", 64'(got.dest_call), 64'(want.dest_call));
                    compare_field("time_to_live", 64'(got.time_to_live),
                                  64'(want.time_to_live));
                    compare_field("circuit", 64'(got.circuit), 64'(want.circuit));
                    compare_field("send_sequence", 64'(got.send_sequence),
                                  64'(want.send_sequence));
                    compare_field("receive_sequence", 64'(got.receive_sequence),
                                  64'(want.receive_sequence));
                    compare_field("frame_kind", 64'(got.frame_kind), 64'(want.frame_kind));
                    compare_field("window_size", 64'(got.window_size),
                                  64'(want.window_size));
                    compare_field("user_call", 64'(got.user_call),
                                  64'(want.user_call));
                    compare_field("node_call", 64'(got.node_call),
                                  64'(want.node_call));
                    compare_field("payload_length", 64'(got.payload_length),
                                  64'(want.payload_length));
                end
            end
            if (s_tvalid && s_tready) begin
                parse_frame_byte(s_tdata, s_tlast);
            end
        end
    end

    initial begin
        int   frames;
        int   start_beats;
        int   r;
        int   kind;
        logic [7:0] lead;
        logic [7:0] opcode;

        // Directed frames: length limits, first-byte limit, every valid opcode, several invalid
        // ones and the order in which the error checks apply.
        queue_frame(1, 8'h00, 8'h00, 1, 0, 0);
        queue_frame(19, 8'hA0, 8'h01, 1, 0, 0);
        queue_frame(19, 8'h60, 8'h01, 0, 0, 0);
        queue_frame(20, 8'h5F, 8'h05, 1, 0, 0);
        queue_frame(20, 8'h10, 8'h00, 1, 0, 0);
        queue_frame(35, 8'h60, 8'h01, 0, 1, 0);
        queue_frame(34, 8'hFF, 8'h01, 1, 0, 0);
        queue_frame(20, 8'h61, 8'hF1, 1, 0, 0);
        queue_frame(60, 8'hFF, 8'h01, 1, 0, 0);
        queue_frame(20, 8'h80, 8'h00, 1, 0, 0);
        queue_frame(20, 8'h80, 8'h07, 0, 0, 0);
        queue_frame(25, 8'h80, 8'hFF, 1, 0, 0);
        queue_frame(20, 8'h70, 8'h02, 1, 0, 0);
        queue_frame(21, 8'h70, 8'h82, 1, 0, 0);
        queue_frame(40, 8'h70, 8'h02, 1, 0, 0);
        queue_frame(20, 8'hC0, 8'h03, 1, 0, 0);
        queue_frame(22, 8'hC0, 8'h04, 0, 0, 0);
        queue_frame(30, 8'hC0, 8'h06, 1, 0, 0);
        queue_frame(20, 8'hFF, 8'h05, 1, 0, 0);
        queue_frame(21, 8'h9A, 8'hF5, 1, 0, 0);

        // Mostly well-formed frames with random content, the rest broken or noise.
        start_beats = frame_beats.size();
        frames = 0;
        while (frame_beats.size() - start_beats < RANDOM_BEATS || frames < RANDOM_FRAMES) begin
            if (frames == 2) begin
                // Short frames back to back while the result side holds off.
                queue_frame(20, 8'h90, 8'h05, 0, 1, 1);
                for (int i = 0; i < 9; i++) begin
                    kind = $urandom_range(3, 6);
                    queue_frame(20, 8'($urandom_range(8'h60, 8'hFF)),
                                {4'($urandom), 4'(kind)}, 0, 0, 0);
                end
                frames += 10;
            end else begin
                r = $urandom_range(0, 99);
                lead = 8'($urandom_range(8'h60, 8'hFF));
                if (r < 65) begin
                    kind = $urandom_range(1, 6);
                    opcode = {4'($urandom), 4'(kind)};
                    queue_frame(kind == 1 ? $urandom_range(35, 45) : $urandom_range(20, 30),
                                lead, opcode, $urandom_range(0, 3) != 0, frames == 13, 0);
                end else if (r < 80) begin
                    queue_frame($urandom_range(1, 40), 8'($urandom), 8'($urandom),
                                $urandom_range(0, 3) != 0, 0, 0);
                end else if (r < 90) begin
                    queue_frame($urandom_range(20, 34), lead, {4'($urandom), 4'(KIND_CREQ)},
                                1, 0, 0);
                end else begin
                    queue_frame($urandom_range(20, 30), 8'($urandom_range(0, 8'h5F)),
                                8'($urandom), 1, 0, 0);
                end
                frames++;
            end
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (frame_beats.size() != 0 || s_tvalid || awaited_results.size() != 0) begin
            @(posedge aclk);
        end
        wind_down = 1'b1;
        repeat (12) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
